@@ src/lpb_pkg.sv @@
package lpb_pkg;

    // Configuration port geometry
    localparam int PADDR_W = 3;
    localparam logic [PADDR_W-1:0] ADDR_ON_LEVEL = 3'd0;

    // Command codes carried in the action field
    typedef enum logic [2:0] {
        ACT_TICK  = 3'd0,
        ACT_PULSE = 3'd1,
        ACT_BLINK = 3'd2,
        ACT_SET   = 3'd3,
        ACT_OFF   = 3'd4
    } action_t;

    // Driver modes
    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_FIXED = 2'd1,
        MODE_PULSE = 2'd2,
        MODE_BLINK = 2'd3
    } mode_t;

    // Input transfer payload
    typedef struct packed {
        logic [2:0]        action;
        logic [31:0]       on_time_ms;
        logic [31:0]       off_time_ms;
        logic signed [7:0] cycle_count;
        logic              level;
    } in_t;

    // Result transfer payload
    typedef struct packed {
        logic       pin_level;
        logic       led_on;
        logic [1:0] mode;
    } out_t;

    // Driver state shared between the top level and the step logic
    typedef struct packed {
        mode_t       mode;
        logic        counted;
        logic        led_state;
        logic [31:0] elapsed_ms;
        logic [6:0]  cycles_left;
        logic [31:0] pulse_len;
        logic [31:0] on_len;
        logic [31:0] off_len;
    } state_t;

endpackage

@@ src/led_pulse_blink_controller.sv @@
// Channel   Direction  Handshake           Payload
// in        input      in_valid/in_stall   lpb_pkg::in_t  (tick or command)
// out       output     out_valid/out_stall lpb_pkg::out_t (state after the item)
// cfg       input      APB psel/penable    pin on-level bit at byte address 0
//
// Each item passes through the input register, then through the step logic into
// the result register. One item per cycle is sustained while out_stall is low.
// Reset leaves the driver idle with the LED off and the on-level bit high.
// A stalled result holds the pipe; the input register still takes a transfer
// while the result register waits, so the input stalls only when both are full.
module led_pulse_blink_controller
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  lpb_pkg::in_t                in_data,
    output logic                        out_valid,
    input  logic                        out_stall,
    output lpb_pkg::out_t               out_data,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [lpb_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    logic            on_level_reg;
    logic            s1_valid_reg;
    lpb_pkg::in_t    s1_item_reg;
    lpb_pkg::state_t state_reg;
    lpb_pkg::state_t state_next;
    lpb_pkg::out_t   result_next;
    logic            out_valid_reg;
    lpb_pkg::out_t   out_data_reg;
    logic            s1_move;
    logic            in_take;

    // Pipe control
    assign s1_move  = s1_valid_reg && !(out_valid_reg && out_stall);
    assign in_stall = s1_valid_reg && !s1_move;
    assign in_take  = in_valid && !in_stall;

    // Configuration register
    assign pready = 1'b1;
    assign prdata = (paddr == lpb_pkg::ADDR_ON_LEVEL) ? {31'd0, on_level_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            on_level_reg <= 1'b1;
        end
        else if (psel && penable && pwrite && (paddr == lpb_pkg::ADDR_ON_LEVEL))
        begin
            on_level_reg <= pwdata[0];
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_take || s1_move)
        begin
            s1_valid_reg <= in_take;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_item_reg <= in_data;
        end
    end

    // Step logic
    lpb_step u_step
    (
        .state      (state_reg),
        .item       (s1_item_reg),
        .on_level   (on_level_reg),
        .state_next (state_next),
        .result     (result_next)
    );

    // Driver state and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_move)
            begin
                state_reg <= state_next;
            end
            if (s1_move || !out_stall)
            begin
                out_valid_reg <= s1_move;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            out_data_reg <= result_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

@@ src/lpb_step.sv @@
module lpb_step
(
    input  lpb_pkg::state_t state,
    input  lpb_pkg::in_t    item,
    input  logic            on_level,
    output lpb_pkg::state_t state_next,
    output lpb_pkg::out_t   result
);

    logic [31:0] elapsed_inc;
    logic        cyc_positive;
    logic [6:0]  cycles_dec;

    // Saturating millisecond count, count positivity, cycle decrement
    assign elapsed_inc  = (state.elapsed_ms == 32'hFFFF_FFFF) ? state.elapsed_ms
                                                              : state.elapsed_ms + 32'd1;
    assign cyc_positive = (item.cycle_count != 8'sd0) && !item.cycle_count[7];
    assign cycles_dec   = state.cycles_left - 7'd1;

    // Next state for one tick or command
    always_comb
    begin
        state_next = state;
        unique case (item.action)
            lpb_pkg::ACT_TICK:
            begin
                if (state.mode == lpb_pkg::MODE_PULSE)
                begin
                    state_next.elapsed_ms = elapsed_inc;
                    if (elapsed_inc >= state.pulse_len)
                    begin
                        state_next.mode      = lpb_pkg::MODE_IDLE;
                        state_next.counted   = 1'b0;
                        state_next.led_state = 1'b0;
                    end
                end
                else if (state.mode == lpb_pkg::MODE_BLINK)
                begin
                    state_next.elapsed_ms = elapsed_inc;
                    if (state.led_state)
                    begin
                        if (elapsed_inc >= state.on_len)
                        begin
                            state_next.led_state  = 1'b0;
                            state_next.elapsed_ms = 32'd0;
                        end
                    end
                    else if (elapsed_inc >= state.off_len)
                    begin
                        // off-to-on edge: one cycle done
                        state_next.led_state  = 1'b1;
                        state_next.elapsed_ms = 32'd0;
                        if (state.counted)
                        begin
                            state_next.cycles_left = cycles_dec;
                            if (cycles_dec == 7'd0)
                            begin
                                state_next.mode      = lpb_pkg::MODE_IDLE;
                                state_next.counted   = 1'b0;
                                state_next.led_state = 1'b0;
                            end
                        end
                    end
                end
            end
            lpb_pkg::ACT_PULSE:
            begin
                if (state.mode != lpb_pkg::MODE_PULSE)
                begin
                    state_next.mode        = lpb_pkg::MODE_PULSE;
                    state_next.counted     = 1'b0;
                    state_next.cycles_left = 7'd0;
                    state_next.pulse_len   = item.on_time_ms;
                    state_next.elapsed_ms  = 32'd0;
                    state_next.led_state   = 1'b1;
                end
            end
            lpb_pkg::ACT_BLINK:
            begin
                if (state.mode != lpb_pkg::MODE_BLINK)
                begin
                    state_next.mode    = lpb_pkg::MODE_BLINK;
                    state_next.counted = cyc_positive;
                    if (cyc_positive)
                    begin
                        state_next.cycles_left = item.cycle_count[6:0];
                    end
                    state_next.on_len     = item.on_time_ms;
                    state_next.off_len    = item.off_time_ms;
                    state_next.elapsed_ms = 32'd0;
                    state_next.led_state  = 1'b1;
                end
            end
            lpb_pkg::ACT_SET:
            begin
                state_next.mode        = lpb_pkg::MODE_FIXED;
                state_next.counted     = 1'b0;
                state_next.cycles_left = 7'd0;
                state_next.led_state   = item.level;
            end
            lpb_pkg::ACT_OFF:
            begin
                if (state.mode == lpb_pkg::MODE_BLINK)
                begin
                    state_next.mode        = lpb_pkg::MODE_FIXED;
                    state_next.counted     = 1'b0;
                    state_next.cycles_left = 7'd0;
                    state_next.led_state   = 1'b0;
                end
            end
            default:
            begin
                // unused codes leave the state alone
            end
        endcase
    end

    // Result after the update
    assign result.pin_level = state_next.led_state ? on_level : ~on_level;
    assign result.led_on    = state_next.led_state;
    assign result.mode      = state_next.mode;

endmodule
